[sv/dual_quadrature_speed_meter_top_defines.svh]
`ifndef DUAL_QUADRATURE_SPEED_METER_TOP_DEFINES_SVH
`define DUAL_QUADRATURE_SPEED_METER_TOP_DEFINES_SVH

// Checks that hold outside reset: when the antecedent holds, the consequent holds.
`define DQSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks on the cycle after the antecedent.
`define DQSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dqsm_pkg.sv]
`default_nettype none

package dqsm_pkg;

  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_READ_SPEED = 2'd1;
  localparam logic [1:0] OP_READ_FAULT = 2'd2;
  localparam logic [1:0] OP_INIT       = 2'd3;

  localparam logic [14:0] WINDOW_RESET = 15'd200;
  localparam logic [7:0]  FAULT_MAX    = 8'hFF;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] sens_right;
    logic [1:0] sens_left;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] speed_right;
    logic signed [15:0] speed_left;
    logic               data_ready;
    logic               error_seen;
  } result_t;

  // Per-motor controls, already qualified by the accepted word.
  typedef struct packed {
    logic tick;
    logic init;
    logic window_end;
  } chan_ctrl_t;

  typedef struct packed {
    logic signed [1:0] step;
    logic              illegal;
  } step_t;

  // Code is {new pair, previous pair}. Both bits changing at once is illegal.
  function automatic step_t decode_step(input logic [3:0] code);
    step_t s;
    s = '{step: 2'sd0, illegal: 1'b0};
    unique case (code)
      4'h2, 4'h4, 4'hB, 4'hD: s.step = -2'sd1;
      4'h1, 4'h7, 4'h8, 4'hE: s.step = 2'sd1;
      4'h3, 4'h6, 4'hC, 4'h9: s.illegal = 1'b1;
      default:                s.step = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/dqsm_channel.sv]
`default_nettype none

module dqsm_channel
  import dqsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire chan_ctrl_t  ctrl,
  input  wire logic [1:0]  sens,
  output logic [15:0]      steps_sum,
  output logic             illegal
);

  logic [1:0]  prev;
  logic [15:0] steps;
  step_t       dec;

  always_comb begin
    dec       = decode_step({sens, prev});
    illegal   = dec.illegal;
    steps_sum = steps + {{14{dec.step[1]}}, dec.step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      steps <= '0;
    end else if (ctrl.tick) begin
      prev  <= sens;
      steps <= ctrl.window_end ? 16'd0 : steps_sum;
    end else if (ctrl.init) begin
      prev  <= sens;
      steps <= '0;
    end
  end

endmodule

`default_nettype wire

[sv/dual_quadrature_speed_meter_top.sv]
// Dual quadrature speed meter.
// Input channel (sample_valid/sample_ready/sample) takes one word per cycle:
// a sample tick with both Hall sensor pairs, a speed read, a fault read that
// clears the fault count, or an init that captures the sensor pairs and
// clears the step and tick counts. Every accepted word gives exactly one
// result word on result_valid/result_ready/result from the single result
// register, in the next cycle. State update and result are computed on
// acceptance, so the rate is one word per clock while result_ready is high.
// While a result waits and result_ready is low, sample_ready is low; when the
// result is taken in the same cycle, a new word is accepted alongside.
// window_we/window_data set the tick count per speed window; write only
// while idle. Synchronous reset clears all counts, speeds and flags, sets the
// window to 200 ticks and empties the result register.
`default_nettype none

module dual_quadrature_speed_meter_top
  import dqsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire sample_t     sample,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result,
  input  wire logic        window_we,
  input  wire logic [14:0] window_data
);

  logic [14:0] window_ticks;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  logic [15:0] latched_right;
  logic [15:0] latched_left;
  logic        fresh_flag;
  logic        fresh_flag_next;
  logic [7:0]  fault_count;
  logic [7:0]  fault_count_next;
  result_t     result_next;

  logic        accept;
  logic        is_tick;
  logic        window_end;
  logic [15:0] tick_inc;
  chan_ctrl_t  ctrl;
  logic [15:0] sum_right;
  logic [15:0] sum_left;
  logic        ill_right;
  logic        ill_left;
  logic [9:0]  fault_sum;

  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;
  assign is_tick      = accept && (sample.op == OP_TICK);
  assign tick_inc     = tick_count + 16'd1;
  assign window_end   = is_tick && (tick_inc >= {1'b0, window_ticks});

  assign ctrl = '{tick: is_tick,
                  init: accept && (sample.op == OP_INIT),
                  window_end: window_end};

  dqsm_channel u_right (
    .clk(clk), .rst(rst), .ctrl(ctrl), .sens(sample.sens_right),
    .steps_sum(sum_right), .illegal(ill_right)
  );

  dqsm_channel u_left (
    .clk(clk), .rst(rst), .ctrl(ctrl), .sens(sample.sens_left),
    .steps_sum(sum_left), .illegal(ill_left)
  );

  always_comb begin
    tick_count_next  = tick_count;
    fresh_flag_next  = fresh_flag;
    fault_count_next = fault_count;
    result_next      = '0;
    // Up to three faults in one tick: two illegal transitions and an overrun.
    fault_sum = {2'b00, fault_count} + {9'd0, ill_right} + {9'd0, ill_left}
              + {9'd0, window_end && fresh_flag};
    unique case (sample.op)
      OP_TICK: begin
        fault_count_next = (fault_sum > {2'b00, FAULT_MAX}) ? FAULT_MAX : fault_sum[7:0];
        if (window_end) begin
          tick_count_next = '0;
          fresh_flag_next = 1'b1;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      OP_READ_SPEED: begin
        if (fresh_flag) begin
          result_next.speed_right = latched_right;
          result_next.speed_left  = latched_left;
          result_next.data_ready  = 1'b1;
          fresh_flag_next         = 1'b0;
        end
      end
      OP_READ_FAULT: begin
        result_next.error_seen = (fault_count != 8'd0);
        fault_count_next       = '0;
      end
      OP_INIT: begin
        tick_count_next = '0;
      end
      default: begin
        tick_count_next = tick_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
    end else if (window_we) begin
      window_ticks <= window_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      latched_right <= '0;
      latched_left  <= '0;
      fresh_flag    <= 1'b0;
      fault_count   <= '0;
    end else if (accept) begin
      tick_count  <= tick_count_next;
      fresh_flag  <= fresh_flag_next;
      fault_count <= fault_count_next;
      if (window_end) begin
        latched_right <= sum_right;
        latched_left  <= sum_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

[sv/dqsm_checker.sv]
`default_nettype none
`include "dual_quadrature_speed_meter_top_defines.svh"

module dqsm_checker
  import dqsm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        sample_valid,
  input wire logic        sample_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire result_t     result
);

  // A stalled result must hold its word.
  `DQSM_ASSERT_NEXT(a_result_hold,
                    result_valid && !result_ready,
                    result_valid && $stable(result),
                    "stalled result word changed")

  // No new word may enter while the result register is full and stalled.
  `DQSM_ASSERT_SAME(a_no_overwrite,
                    result_valid && !result_ready,
                    !sample_ready,
                    "word accepted over a stalled result")

  // A speed read and a fault read never answer at once.
  `DQSM_ASSERT_SAME(a_one_kind,
                    result_valid,
                    !(result.data_ready && result.error_seen),
                    "result flags both set")

  // Speeds are shown only with the new-data flag.
  `DQSM_ASSERT_SAME(a_speed_zero,
                    result_valid && !result.data_ready,
                    result.speed_right == 16'sd0 && result.speed_left == 16'sd0,
                    "speed shown without new data")

  // Every accepted word yields a result in the next cycle.
  `DQSM_ASSERT_NEXT(a_result_follows,
                    sample_valid && sample_ready,
                    result_valid,
                    "accepted word gave no result")

endmodule

bind dual_quadrature_speed_meter_top dqsm_checker u_dqsm_checker (.*);

`default_nettype wire

[tb/speed_meter_monitor.sv]
module speed_meter_monitor
  import dqsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  input  logic        sample_ready,
  input  sample_t     sample,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  input  logic        window_we,
  input  logic [14:0] window_data,
  output int          pending_words,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [14:0] window_len;
  logic [1:0]  last_right;
  logic [1:0]  last_left;
  logic [15:0] sum_right;
  logic [15:0] sum_left;
  logic [15:0] ticks_in_window;
  logic [15:0] held_right;
  logic [15:0] held_left;
  logic        speeds_fresh;
  logic [7:0]  fault_total;
  int          bad_words;
  result_t     expected_readings[$];

  function automatic void count_fault();
    if (fault_total != FAULT_MAX) begin
      fault_total = fault_total + 8'd1;
    end
  endfunction

  // Gray positions 00, 01, 11, 10 count up; the meter steps +1 when the
  // position moves down by one. A move by two means both bits flipped.
  function automatic int hall_step(input logic [1:0] was, input logic [1:0] now);
    logic [1:0] moved;
    moved = {was[1], was[1] ^ was[0]} - {now[1], now[1] ^ now[0]};
    case (moved)
      2'd1: return 1;
      2'd3: return -1;
      2'd2: begin
        count_fault();
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic result_t meter_response(input sample_t w);
    result_t res;
    res = '0;
    case (w.op)
      OP_TICK: begin
        sum_right = sum_right + 16'(hall_step(last_right, w.sens_right));
        sum_left = sum_left + 16'(hall_step(last_left, w.sens_left));
        last_right = w.sens_right;
        last_left = w.sens_left;
        ticks_in_window = ticks_in_window + 16'd1;
        // A lowered window still ends here, since the count may already be past it.
        if (ticks_in_window >= {1'b0, window_len}) begin
          held_right = sum_right;
          held_left = sum_left;
          if (speeds_fresh) begin
            count_fault();
          end
          speeds_fresh = 1'b1;
          sum_right = '0;
          sum_left = '0;
          ticks_in_window = '0;
        end
      end
      OP_READ_SPEED: begin
        if (speeds_fresh) begin
          res.speed_right = held_right;
          res.speed_left = held_left;
          res.data_ready = 1'b1;
          speeds_fresh = 1'b0;
        end
      end
      OP_READ_FAULT: begin
        if (fault_total != 8'd0) begin
          fault_total = '0;
          res.error_seen = 1'b1;
        end
      end
      default: begin
        last_right = w.sens_right;
        last_left = w.sens_left;
        sum_right = '0;
        sum_left = '0;
        ticks_in_window = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      window_len = WINDOW_RESET;
      last_right = '0;
      last_left = '0;
      sum_right = '0;
      sum_left = '0;
      ticks_in_window = '0;
      held_right = '0;
      held_left = '0;
      speeds_fresh = 1'b0;
      fault_total = '0;
      bad_words = 0;
      expected_readings.delete();
    end else begin
      if (window_we) begin
        window_len = window_data;
      end
      if (result_valid && result_ready) begin
        if (expected_readings.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("%0t: result word with nothing outstanding: speed_right=%0d speed_left=%0d",
                     $time, result.speed_right, result.speed_left,
                     " data_ready=%0b error_seen=%0b", result.data_ready, result.error_seen);
          end
        end else begin
          want = expected_readings.pop_front();
          if (result.speed_right !== want.speed_right || result.speed_left !== want.speed_left
              || result.data_ready !== want.data_ready
              || result.error_seen !== want.error_seen) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("%0t: wrong result word: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                       $time, want.speed_right, want.speed_left, want.data_ready,
                       want.error_seen, result.speed_right, result.speed_left,
                       result.data_ready, result.error_seen);
            end
          end
        end
      end
      if (sample_valid && sample_ready) begin
        expected_readings.push_back(meter_response(sample));
      end
    end
    pending_words <= expected_readings.size();
    mismatches <= bad_words;
  end

endmodule

[tb/tb_dual_quadrature_speed_meter_top.sv]
module tb_dual_quadrature_speed_meter_top;
  import dqsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        window_we = 1'b0;
  logic [14:0] window_data = '0;

  int          pending_words;
  int          mismatches;
  int          idle_cycles = 0;
  int          hold_left = 0;
  bit          no_idle = 1'b0;
  logic [1:0]  hall_right = '0;
  logic [1:0]  hall_left = '0;

  dual_quadrature_speed_meter_top uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .window_we    (window_we),
    .window_data  (window_data)
  );

  speed_meter_monitor monitor (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .window_we     (window_we),
    .window_data   (window_data),
    .pending_words (pending_words),
    .mismatches    (mismatches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      result_ready <= 1'b0;
      hold_left <= idle_len();
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("dual_quadrature_speed_meter_top: mismatch");
        $finish;
      end
    end
  end

  function automatic sample_t word_of(input logic [1:0] op, input logic [1:0] sr,
                                      input logic [1:0] sl);
    sample_t w;
    w.op = op;
    w.sens_right = sr;
    w.sens_left = sl;
    return w;
  endfunction

  // Moves one encoder along its Gray sequence, mostly in the chosen direction,
  // with some holds, reversals and arbitrary jumps.
  function automatic logic [1:0] next_pair(input logic [1:0] p, input int dir);
    logic [1:0] pos;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 2'($urandom);
    if (r < 25) return p;
    pos = {p[1], p[1] ^ p[0]};
    pos = (r < 85) ? pos - 2'(dir) : pos + 2'(dir);
    return {pos[1], pos[1] ^ pos[0]};
  endfunction

  function automatic sample_t random_word(input bit storm, input int dir_r, input int dir_l);
    sample_t w;
    int r;
    r = $urandom_range(0, 99);
    w.sens_right = 2'($urandom);
    w.sens_left = 2'($urandom);
    if (storm) begin
      w.op = (r < 90) ? OP_TICK : OP_READ_SPEED;
    end else if (r < 70) begin
      w.op = OP_TICK;
    end else if (r < 84) begin
      w.op = OP_READ_SPEED;
    end else if (r < 92) begin
      w.op = OP_READ_FAULT;
    end else begin
      w.op = OP_INIT;
    end
    if (w.op == OP_TICK) begin
      // A storm flips both bits of each pair on every tick.
      w.sens_right = storm ? ~hall_right : next_pair(hall_right, dir_r);
      w.sens_left = storm ? ~hall_left : next_pair(hall_left, dir_l);
    end
    return w;
  endfunction

  task automatic send_word(input sample_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= w;
    if (w.op == OP_TICK || w.op == OP_INIT) begin
      hall_right = w.sens_right;
      hall_left = w.sens_left;
    end
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic set_window(input logic [14:0] len);
    drain();
    repeat (2) @(posedge clk);
    window_we <= 1'b1;
    window_data <= len;
    @(posedge clk);
    window_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [14:0] len, input int words, input bit storm,
                           input bit quiet);
    int dir_r;
    int dir_l;
    set_window(len);
    no_idle = quiet;
    dir_r = $urandom_range(0, 1) ? 1 : -1;
    dir_l = $urandom_range(0, 1) ? 1 : -1;
    repeat (words) send_word(random_word(storm, dir_r, dir_l));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_window(15'd4);
    send_word(word_of(OP_READ_SPEED, 2'b11, 2'b11));
    send_word(word_of(OP_READ_FAULT, 2'b11, 2'b11));
    send_word(word_of(OP_INIT, 2'b00, 2'b00));
    // One full window: right steps down four times, left steps up four times.
    send_word(word_of(OP_TICK, 2'b01, 2'b10));
    send_word(word_of(OP_TICK, 2'b11, 2'b11));
    send_word(word_of(OP_TICK, 2'b10, 2'b01));
    send_word(word_of(OP_TICK, 2'b00, 2'b00));
    send_word(word_of(OP_READ_SPEED, 2'b00, 2'b00));
    send_word(word_of(OP_READ_SPEED, 2'b00, 2'b00));
    // Double changes on both motors, then on the right one alone.
    send_word(word_of(OP_TICK, 2'b11, 2'b11));
    send_word(word_of(OP_TICK, 2'b00, 2'b00));
    send_word(word_of(OP_TICK, 2'b11, 2'b00));
    send_word(word_of(OP_TICK, 2'b11, 2'b00));
    // A third window ends before the speeds of the second are read: an overrun.
    repeat (4) send_word(word_of(OP_TICK, 2'b11, 2'b00));
    send_word(word_of(OP_READ_FAULT, 2'b01, 2'b10));
    send_word(word_of(OP_READ_FAULT, 2'b10, 2'b01));
    send_word(word_of(OP_READ_SPEED, 2'b01, 2'b01));
    send_word(word_of(OP_TICK, 2'b10, 2'b01));
    send_word(word_of(OP_INIT, 2'b11, 2'b10));
    send_word(word_of(OP_TICK, 2'b01, 2'b11));
    send_word(word_of(OP_READ_SPEED, 2'b10, 2'b10));

    run_phase(15'd200, 250, 1'b0, 1'b0);
    run_phase(15'd1, 180, 1'b0, 1'b0);
    run_phase(15'd0, 150, 1'b0, 1'b0);
    run_phase(15'd32767, 200, 1'b0, 1'b0);
    run_phase(15'd6, 200, 1'b0, 1'b0);
    run_phase(15'd50, 300, 1'b1, 1'b0);
    run_phase(15'd2, 150, 1'b0, 1'b0);
    run_phase(15'd13, 120, 1'b0, 1'b1);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("dual_quadrature_speed_meter_top: match");
    end else begin
      $display("dual_quadrature_speed_meter_top: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/dqsm_pkg.sv
sv/dqsm_channel.sv
sv/dual_quadrature_speed_meter_top.sv
sv/dqsm_checker.sv
tb/speed_meter_monitor.sv
tb/tb_dual_quadrature_speed_meter_top.sv
